// File: hdl/sorted_priority_queue_defines.svh
// Assertion macros used by the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Clocked check, held off while reset is high.
`define SPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also runs during reset.
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/spq_pkg.sv
// Types and constants shared by the sorted priority queue.
package spq_pkg;

   localparam int KEY_W   = 16;
   localparam int COUNT_W = 5;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DELETE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // operation broadcast to every cell; insert and remove are already qualified
   typedef struct packed {
      logic                    insert;
      logic                    remove;
      logic signed [KEY_W-1:0] key;
   } cell_ctl_type;

   // compare results a cell hands to its right-hand neighbour
   typedef struct packed {
      logic ins_ge;
      logic del_ge;
   } cell_cmp_type;

endpackage

// File: hdl/spq_cell.sv
// One compare-and-shift cell of the sorted priority queue.
module spq_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  spq_pkg::cell_ctl_type            ctl,
   input  logic signed [spq_pkg::KEY_W-1:0] left_value,
   input  logic                             left_valid,
   input  spq_pkg::cell_cmp_type            left_cmp,
   input  logic signed [spq_pkg::KEY_W-1:0] right_value,
   input  logic                             right_valid,
   output logic signed [spq_pkg::KEY_W-1:0] value,
   output logic                             valid,
   output spq_pkg::cell_cmp_type            cmp,
   output logic                             hit
);
   import spq_pkg::*;

   logic signed [KEY_W-1:0] value_ff, value_in;
   logic                    valid_ff, valid_in;

   // entries are kept descending, so both compares are monotone along the valid entries
   always_comb begin
      cmp.ins_ge = !valid_ff || (ctl.key >= value_ff);
      cmp.del_ge = valid_ff && (ctl.key >= value_ff);
      hit        = valid_ff && (value_ff == ctl.key) && !left_cmp.del_ge;
   end

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      priority if (ctl.insert) begin
         if (left_cmp.ins_ge) begin
            value_in = left_value;
            valid_in = left_valid;
         end else if (cmp.ins_ge) begin
            value_in = ctl.key;
            valid_in = 1'b1;
         end
      end else if (ctl.remove) begin
         if (cmp.del_ge) begin
            value_in = right_value;
            valid_in = right_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// File: hdl/sorted_priority_queue.sv
// Sorted priority queue top level: request/response channels and a row of cells.
//
// Holds up to DEPTH signed 16-bit keys in descending order, largest at the head.
// Request word: req_tuser is the command (0 insert, 1 delete first equal key),
// req_tdata carries the key. Each request gives exactly one response word with
// status (done, full, not found), the count after the operation and the head.
// Every cell compares the broadcast key with its own entry and takes its
// neighbour's entry in the same cycle, so the response appears in the cycle
// after the request is taken, and one request per cycle is sustained while
// the receiver keeps rsp_tready high.
// A finished response waits in the output register; a new request is taken in
// the cycle that word leaves, so a stalled receiver stalls the request side.
// Synchronous reset empties the queue and drops any pending response; the
// stored keys themselves are not cleared, only their valid bits.
module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [1:0] status, [6:2] count, [7] head_valid,
                                    // [23:8] head_value
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic signed [KEY_W-1:0] cell_value [DEPTH];
   logic                    cell_valid [DEPTH];
   cell_cmp_type            cell_cmp   [DEPTH];
   logic [DEPTH-1:0]        cell_hit;

   cell_ctl_type  ctl;
   logic          accept;
   logic          full;
   logic          found;
   cmd_type       cmd;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    status_ff, status_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW+COUNT_W-1:0] count_ext;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign full       = cell_valid[DEPTH-1];
   assign found      = |cell_hit;

   always_comb begin
      ctl.key    = req_tdata;
      ctl.insert = accept && (cmd == CMD_INSERT) && !full;
      ctl.remove = accept && (cmd == CMD_DELETE) && found;
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic signed [KEY_W-1:0] lv, rv;
      logic                    lval, rval;
      cell_cmp_type            lcmp;

      if (k == 0) begin : g_first
         assign lv   = '0;
         assign lval = 1'b0;
         assign lcmp = '0;
      end else begin : g_mid
         assign lv   = cell_value[k-1];
         assign lval = cell_valid[k-1];
         assign lcmp = cell_cmp[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign rv   = '0;
         assign rval = 1'b0;
      end else begin : g_body
         assign rv   = cell_value[k+1];
         assign rval = cell_valid[k+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_value  (lv),
         .left_valid  (lval),
         .left_cmp    (lcmp),
         .right_value (rv),
         .right_valid (rval),
         .value       (cell_value[k]),
         .valid       (cell_valid[k]),
         .cmp         (cell_cmp[k]),
         .hit         (cell_hit[k])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.remove) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      unique case (cmd)
         CMD_INSERT: status_in = full ? ST_FULL : ST_DONE;
         CMD_DELETE: status_in = found ? ST_DONE : ST_NOT_FOUND;
         default:    status_in = ST_DONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   // cells only move on an accepted word, which also reloads the response,
   // so the head can be read straight from the first cell
   assign count_ext = {{COUNT_W{1'b0}}, count_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {cell_valid[0] ? cell_value[0] : {KEY_W{1'b0}},
                        cell_valid[0],
                        count_ext[COUNT_W-1:0],
                        status_ff};

`include "sorted_priority_queue_defines.svh"

   `SPQ_ASSERT(a_count_range, clock, reset, count_ff <= CW'(DEPTH), "count beyond depth")
   `SPQ_ASSERT(a_head_vs_count, clock, reset, cell_valid[0] == (count_ff != '0), "head valid disagrees with count")
   `SPQ_ASSERT(a_full_hold, clock, reset, (accept && cmd == CMD_INSERT && full) |=> (count_ff == $past(count_ff)), "rejected insert changed count")
   `SPQ_ASSERT(a_order, clock, reset, cell_valid[1] |-> (cell_value[0] >= cell_value[1]), "head entries out of order")
   `SPQ_ASSERT_ALWAYS(a_reset_empty, clock, (!reset && $past(reset)) |-> (!rsp_valid_ff && count_ff == '0), "queue not empty after reset")

endmodule

// File: test/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: directed table, then random words.
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int RANDOM_WORDS = 1650;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 100;

   typedef struct {
      status_type                status;
      logic [COUNT_W-1:0]        count;
      logic                      head_valid;
      logic signed [KEY_W-1:0]   head_value;
   } queue_outcome;

   typedef struct {
      cmd_type                   cmd;
      logic signed [KEY_W-1:0]   key;
      bit                        typed;
      queue_outcome              want;
   } step_row;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = '0;     // [15:0] value
   logic        req_tuser  = 1'b0;   // [0] command
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [23:0] rsp_tdata;           // [1:0] status, [6:2] count, [7] head_valid,
                                     // [23:8] head_value

   // travels alongside the request word so the checker sees it at the same edge
   bit           word_typed    = 1'b0;
   queue_outcome typed_outcome = '{ST_DONE, 5'd0, 1'b0, 16'sd0};

   // predictor state
   logic signed [KEY_W-1:0] held_keys[DEPTH];
   int                      held_count = 0;
   bit                      filling    = 1'b1;

   queue_outcome pending_outcomes[$];

   int words_sent     = 0;
   int send_idle_pct  = 21;
   int recv_idle_pct  = 63;
   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int inserts_done   = 0;
   int deletes_done   = 0;
   int full_rejects   = 0;
   int misses         = 0;
   int responses_seen = 0;

   step_row directed_steps[25];

   sorted_priority_queue #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one operation to the held keys and returns the outcome word.
   function automatic queue_outcome apply_queue_op(cmd_type cmd, logic signed [KEY_W-1:0] key);
      queue_outcome res;
      int pos;
      res.status = ST_DONE;
      if (cmd == CMD_INSERT) begin
         if (held_count >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            pos = held_count;
            // ahead of the first key not greater, so the newest of equals leads
            for (int k = held_count - 1; k >= 0; k--) begin
               if (key >= held_keys[k]) pos = k;
            end
            for (int k = held_count; k > pos; k--) held_keys[k] = held_keys[k-1];
            held_keys[pos] = key;
            held_count++;
         end
      end else begin
         pos = -1;
         for (int k = held_count - 1; k >= 0; k--) begin
            if (held_keys[k] == key) pos = k;
         end
         if (pos < 0) begin
            res.status = ST_NOT_FOUND;
         end else begin
            for (int k = pos; k + 1 < held_count; k++) held_keys[k] = held_keys[k+1];
            held_count--;
         end
      end
      res.count      = COUNT_W'(held_count);
      res.head_valid = (held_count > 0);
      res.head_value = (held_count > 0) ? held_keys[0] : '0;
      return res;
   endfunction

   function automatic step_row plain_step(cmd_type cmd, logic signed [KEY_W-1:0] key);
      step_row s;
      s.cmd   = cmd;
      s.key   = key;
      s.typed = 1'b0;
      s.want  = '{ST_DONE, 5'd0, 1'b0, 16'sd0};
      return s;
   endfunction

   function automatic step_row typed_step(cmd_type cmd, logic signed [KEY_W-1:0] key,
                                          status_type st, logic [COUNT_W-1:0] cnt,
                                          logic hv, logic signed [KEY_W-1:0] head);
      step_row s;
      s.cmd   = cmd;
      s.key   = key;
      s.typed = 1'b1;
      s.want  = '{st, cnt, hv, head};
      return s;
   endfunction

   // Mix of wide random keys, near-zero keys (plenty of duplicates), extremes
   // and copies of keys already held.
   function automatic logic signed [KEY_W-1:0] random_key();
      logic signed [KEY_W-1:0] key;
      case ($urandom_range(9))
         0, 1, 2, 3: key = 16'($urandom);
         4, 5, 6:    key = 16'(int'($urandom_range(6)) - 3);
         7: begin
            case ($urandom_range(3))
               0:       key = 16'sh7fff;
               1:       key = 16'sh8000;
               2:       key = 16'sd0;
               default: key = -16'sd1;
            endcase
         end
         default: key = (held_count > 0) ? held_keys[$urandom_range(held_count - 1)]
                                         : 16'($urandom);
      endcase
      return key;
   endfunction

   // Sweeps the fill level between empty and full; deletes mostly hit a held key.
   function automatic step_row pick_random_step();
      cmd_type                 cmd;
      logic signed [KEY_W-1:0] key;
      if (held_count == 0) filling = 1'b1;
      else if (held_count == DEPTH && $urandom_range(99) < 40) filling = 1'b0;
      if ($urandom_range(99) < (filling ? 80 : 20)) begin
         cmd = CMD_INSERT;
         key = random_key();
      end else begin
         cmd = CMD_DELETE;
         if (held_count > 0 && $urandom_range(99) < 70)
            key = held_keys[$urandom_range(held_count - 1)];
         else
            key = random_key();
      end
      return plain_step(cmd, key);
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Entered and left at a falling edge.
   task automatic send_word(step_row s);
      if (words_sent < (25 + RANDOM_WORDS) / 3) begin
         send_idle_pct = 21;
         recv_idle_pct = 63;
      end else if (words_sent < 2 * (25 + RANDOM_WORDS) / 3) begin
         send_idle_pct = 63;
         recv_idle_pct = 21;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tuser     <= s.cmd;
      req_tdata     <= s.key;
      word_typed    <= s.typed;
      typed_outcome <= s.want;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      @(negedge clock);
   endtask

   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response check first, then the word taken at this edge is predicted.
   always @(posedge clock) begin
      queue_outcome got;
      queue_outcome want;
      queue_outcome predicted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status     = status_type'(rsp_tdata[1:0]);
            got.count      = rsp_tdata[6:2];
            got.head_valid = rsp_tdata[7];
            got.head_value = rsp_tdata[23:8];
            if (pending_outcomes.size() == 0) begin
               report_mismatch($sformatf("response word %0d with nothing outstanding",
                                         responses_seen));
            end else begin
               want = pending_outcomes.pop_front();
               if (got.status !== want.status)
                  report_mismatch($sformatf("word %0d status %0d, want %0d",
                                            responses_seen, got.status, want.status));
               if (got.count !== want.count)
                  report_mismatch($sformatf("word %0d count %0d, want %0d",
                                            responses_seen, got.count, want.count));
               if (got.head_valid !== want.head_valid)
                  report_mismatch($sformatf("word %0d head_valid %0b, want %0b",
                                            responses_seen, got.head_valid, want.head_valid));
               if (got.head_value !== want.head_value)
                  report_mismatch($sformatf("word %0d head_value %0d, want %0d",
                                            responses_seen, got.head_value, want.head_value));
            end
            responses_seen++;
         end
         if (req_tvalid && req_tready) begin
            predicted = apply_queue_op(cmd_type'(req_tuser), req_tdata);
            pending_outcomes.push_back(word_typed ? typed_outcome : predicted);
            case (predicted.status)
               ST_FULL:      full_rejects++;
               ST_NOT_FOUND: misses++;
               default: begin
                  if (req_tuser == CMD_INSERT) inserts_done++;
                  else deletes_done++;
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("no word moved for %0d cycles, %0d responses outstanding",
                  quiet_cycles, pending_outcomes.size());
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      directed_steps = '{
         typed_step(CMD_DELETE, 16'sd0,     ST_NOT_FOUND, 5'd0, 1'b0, 16'sd0),
         typed_step(CMD_INSERT, 16'sh8000,  ST_DONE,      5'd1, 1'b1, 16'sh8000),
         typed_step(CMD_INSERT, 16'sh7fff,  ST_DONE,      5'd2, 1'b1, 16'sh7fff),
         plain_step(CMD_INSERT, 16'sd0),
         plain_step(CMD_INSERT, 16'sd0),
         plain_step(CMD_INSERT, -16'sd1),
         typed_step(CMD_DELETE, 16'sd5,     ST_NOT_FOUND, 5'd5, 1'b1, 16'sh7fff),
         plain_step(CMD_DELETE, 16'sh7fff),
         plain_step(CMD_DELETE, 16'sh8000),
         plain_step(CMD_INSERT, 16'sh5555),
         plain_step(CMD_INSERT, 16'shaaaa),
         plain_step(CMD_INSERT, 16'sd1),
         plain_step(CMD_INSERT, -16'sd2),
         plain_step(CMD_INSERT, 16'sh7fff),
         plain_step(CMD_INSERT, 16'sh7fff),
         plain_step(CMD_INSERT, 16'sd100),
         plain_step(CMD_INSERT, -16'sd100),
         plain_step(CMD_INSERT, 16'sh7ffe),
         plain_step(CMD_INSERT, 16'sh8001),
         plain_step(CMD_INSERT, 16'sh0f0f),
         plain_step(CMD_INSERT, 16'shf0f0),
         plain_step(CMD_INSERT, 16'sd2),
         // queue is full here
         typed_step(CMD_INSERT, 16'sh7fff,  ST_FULL,      5'd16, 1'b1, 16'sh7fff),
         plain_step(CMD_DELETE, 16'sh1234),
         plain_step(CMD_DELETE, 16'sd0)
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) send_word(directed_steps[i]);
      repeat (RANDOM_WORDS) send_word(pick_random_step());
      req_tvalid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words sent, %0d responses checked under three stall patterns",
               words_sent, responses_seen);
      $display("inserts %0d, deletes %0d, full rejects %0d, misses %0d, mismatches %0d",
               inserts_done, deletes_done, full_rejects, misses, mismatch_count);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
test/tb_sorted_priority_queue.sv
